// ----- hw/rtl/ffba_pkg.sv -----
// shared types, codes and defaults for the first-fit block allocator
// no dependencies
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 32;
  localparam int unsigned CONST_ALIGN_DEF = 16;
  localparam logic [31:0] POOL_SIZE_RST   = 32'd1048576;

  localparam logic       CMD_ALLOC     = 1'b0;
  localparam logic       CMD_FREE      = 1'b1;
  localparam logic [1:0] KIND_CONSTANT = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_NO_MATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  typedef struct packed {
    logic        command;
    logic [1:0]  buffer_kind;
    logic [31:0] request_size;
    logic [31:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_offset;
    logic [31:0] granted_size;
    logic [31:0] used_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0] off;
    logic [32:0] len;
    logic        fr;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_SH_RD, S_SH_WR, S_SPLIT_A, S_SPLIT_B,
    S_FR_NRD, S_FR_NCHK, S_FR_PRD, S_FR_PCHK, S_FR_WR, S_CMP_RD, S_CMP_WR, S_DONE
  } state_t;

endpackage

// ----- hw/rtl/first_fit_block_allocator_core.sv -----
// Each command walks the block table, which sits in a memory with one read and one write port;
// each entry is read in S_RD and checked in S_CHK. A split first moves the entries above the
// chosen one up by one place (S_SH_RD, S_SH_WR) and then writes both halves, and a free checks
// the next and the previous neighbour, writes the merged entry and moves entries down when blocks
// merge. A zero-size command goes straight to its result without reading the table. A waiting
// result holds the block until it is taken. Input ready is high only between commands and never
// during a pool_size write, which reloads the table. CONST_ALIGN must be a power of two.
// top level of the first-fit block allocator; depends on ffba_pkg
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned CONST_ALIGN = ffba_pkg::CONST_ALIGN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffba_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import ffba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [32:0] ALIGN_MASK = 33'(CONST_ALIGN - 1);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_r;
  logic          we;
  logic [IW-1:0] wa, ra;
  entry_t        wd;

  state_t state_r, state_nxt;
  logic [31:0] pool_r, pool_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt, j_r, j_nxt, start_r, start_nxt;
  logic [1:0] k_r, k_nxt;
  logic [31:0] used_r, used_nxt;
  in_item_t cmd_r, cmd_nxt;
  logic [32:0] need_r, need_nxt;
  entry_t ent_r, ent_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt, res_r, res_nxt;
  logic [32:0] used_sum;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_r      <= POOL_SIZE_RST;
      cnt_r       <= CW'(1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    start_r <= start_nxt;
    k_r     <= k_nxt;
    cmd_r   <= cmd_nxt;
    need_r  <= need_nxt;
    ent_r   <= ent_nxt;
    out_r   <= out_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pool_nxt = pool_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    j_nxt = j_r;
    start_nxt = start_r;
    k_nxt = k_r;
    used_nxt = used_r;
    cmd_nxt = cmd_r;
    need_nxt = need_r;
    ent_nxt = ent_r;
    out_nxt = out_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready = 1'b0;
    we = 1'b0;
    wa = idx_r[IW-1:0];
    wd = ent_r;
    ra = idx_r[IW-1:0];
    used_sum = {1'b0, used_r} + need_r;
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{off: 32'd0, len: {1'b0, pool_r}, fr: 1'b1};
        cnt_nxt = CW'(1);
        used_nxt = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !cfg_we;
        if (in_valid && !cfg_we) begin
          cmd_nxt = in_data;
          idx_nxt = '0;
          if (in_data.command == CMD_ALLOC && in_data.buffer_kind == KIND_CONSTANT) begin
            need_nxt = ({1'b0, in_data.request_size} + ALIGN_MASK) & ~ALIGN_MASK;
          end else begin
            need_nxt = {1'b0, in_data.request_size};
          end
          res_nxt = '{status: ST_OK, result_offset: 32'd0, granted_size: 32'd0,
                      used_bytes: 32'd0};
          if (in_data.request_size == 32'd0) begin
            res_nxt.status = ST_ZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r.command == CMD_ALLOC) begin
          if (rdata_r.fr && rdata_r.len >= need_r) begin
            ent_nxt = rdata_r;
            if (rdata_r.len == need_r) begin
              we = 1'b1;
              wd = '{off: rdata_r.off, len: rdata_r.len, fr: 1'b0};
              used_nxt = used_sum[31:0];
              res_nxt.result_offset = rdata_r.off;
              res_nxt.granted_size = need_r[31:0];
              state_nxt = S_DONE;
            end else if (cnt_r == CW'(MAX_BLOCKS)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              j_nxt = cnt_r;
              state_nxt = (cnt_r > idx_r + CW'(1)) ? S_SH_RD : S_SPLIT_A;
            end
          end else if (idx_r + CW'(1) >= cnt_r) begin
            res_nxt.status = ST_NO_FIT;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end else begin
          if (!rdata_r.fr && rdata_r.off == cmd_r.block_offset &&
              rdata_r.len == {1'b0, cmd_r.request_size}) begin
            ent_nxt = rdata_r;
            ent_nxt.fr = 1'b1;
            start_nxt = idx_r;
            k_nxt = '0;
            used_nxt = (used_r >= cmd_r.request_size) ? used_r - cmd_r.request_size : 32'd0;
            res_nxt.granted_size = cmd_r.request_size;
            if (idx_r + CW'(1) < cnt_r) begin
              state_nxt = S_FR_NRD;
            end else if (idx_r != '0) begin
              state_nxt = S_FR_PRD;
            end else begin
              state_nxt = S_FR_WR;
            end
          end else if (idx_r + CW'(1) >= cnt_r) begin
            res_nxt.status = ST_NO_MATCH;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_SH_RD: begin
        ra = IW'(j_r - CW'(1));
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we = 1'b1;
        wa = j_r[IW-1:0];
        wd = rdata_r;
        j_nxt = j_r - CW'(1);
        state_nxt = (j_r - CW'(1) > idx_r + CW'(1)) ? S_SH_RD : S_SPLIT_A;
      end
      S_SPLIT_A: begin
        we = 1'b1;
        wd = '{off: ent_r.off, len: need_r, fr: 1'b0};
        state_nxt = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        we = 1'b1;
        wa = IW'(idx_r + CW'(1));
        wd = '{off: ent_r.off + need_r[31:0], len: ent_r.len - need_r, fr: 1'b1};
        cnt_nxt = cnt_r + CW'(1);
        used_nxt = used_sum[31:0];
        res_nxt.result_offset = ent_r.off;
        res_nxt.granted_size = need_r[31:0];
        state_nxt = S_DONE;
      end
      S_FR_NRD: begin
        ra = IW'(idx_r + CW'(1));
        state_nxt = S_FR_NCHK;
      end
      S_FR_NCHK: begin
        if (rdata_r.fr) begin
          ent_nxt.len = ent_r.len + rdata_r.len;
          k_nxt = 2'd1;
        end
        state_nxt = (idx_r != '0) ? S_FR_PRD : S_FR_WR;
      end
      S_FR_PRD: begin
        ra = IW'(idx_r - CW'(1));
        state_nxt = S_FR_PCHK;
      end
      S_FR_PCHK: begin
        if (rdata_r.fr) begin
          ent_nxt.off = rdata_r.off;
          ent_nxt.len = ent_r.len + rdata_r.len;
          start_nxt = idx_r - CW'(1);
          k_nxt = k_r + 2'd1;
        end
        state_nxt = S_FR_WR;
      end
      S_FR_WR: begin
        we = 1'b1;
        wa = start_r[IW-1:0];
        wd = ent_r;
        j_nxt = start_r + CW'(1);
        if (k_r != '0 && start_r + CW'(1) + CW'(k_r) < cnt_r) begin
          state_nxt = S_CMP_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(k_r);
          state_nxt = S_DONE;
        end
      end
      S_CMP_RD: begin
        ra = IW'(j_r + CW'(k_r));
        state_nxt = S_CMP_WR;
      end
      S_CMP_WR: begin
        we = 1'b1;
        wa = j_r[IW-1:0];
        wd = rdata_r;
        j_nxt = j_r + CW'(1);
        if (j_r + CW'(1) + CW'(k_r) < cnt_r) begin
          state_nxt = S_CMP_RD;
        end else begin
          cnt_nxt = cnt_r - CW'(k_r);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = res_r;
          out_nxt.used_bytes = used_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
    if (cfg_we) begin
      pool_nxt = cfg_wdata;
      state_nxt = S_INIT;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sim/first_fit_block_allocator_core_tb.sv -----
// testbench for the first-fit block allocator core: directed and random command streams
// checked against a behavioural table model kept here; depends on ffba_pkg and the core
module first_fit_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int NBLK = 32;
  localparam int ALIGN = 16;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  first_fit_block_allocator_core uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // allocator image
  logic [31:0] blk_off [NBLK];
  logic [32:0] blk_len [NBLK];
  logic        blk_fr  [NBLK];
  int          blk_cnt;
  logic [31:0] in_use;
  logic [31:0] pool_bytes;

  out_item_t pending_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int idle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // used blocks known to the stimulus, for well-formed frees
  logic [31:0] live_off[$];
  logic [31:0] live_len[$];

  task automatic table_reload(input logic [31:0] sz);
    pool_bytes = sz;
    for (int i = 0; i < NBLK; i++) begin
      blk_off[i] = '0; blk_len[i] = '0; blk_fr[i] = 1'b0;
    end
    blk_len[0] = {1'b0, sz};
    blk_fr[0] = 1'b1;
    blk_cnt = 1;
    in_use = '0;
    live_off.delete();
    live_len.delete();
  endtask

  task automatic drop_entry(input int at);
    for (int i = at; i + 1 < blk_cnt; i++) begin
      blk_off[i] = blk_off[i+1]; blk_len[i] = blk_len[i+1]; blk_fr[i] = blk_fr[i+1];
    end
    blk_cnt--;
    blk_off[blk_cnt] = '0; blk_len[blk_cnt] = '0; blk_fr[blk_cnt] = 1'b0;
  endtask

  task automatic join_next(input int at);
    if (at + 1 < blk_cnt && blk_fr[at] && blk_fr[at+1] &&
        {1'b0, blk_off[at]} + blk_len[at] == {1'b0, blk_off[at+1]}) begin
      blk_len[at] = blk_len[at] + blk_len[at+1];
      drop_entry(at + 1);
    end
  endtask

  function automatic logic [32:0] rounded_need(input logic [1:0] kind, input logic [31:0] sz);
    logic [33:0] r;
    r = {2'b0, sz};
    if (kind == KIND_CONSTANT) r = ((r + (ALIGN - 1)) / ALIGN) * ALIGN;
    return r[32:0];
  endfunction

  task automatic predict_command(input in_item_t it, output out_item_t res);
    logic [32:0] need;
    int i;
    res = '0;
    if (it.request_size == 0) begin
      res.status = ST_ZERO;
    end else if (it.command == CMD_ALLOC) begin
      need = rounded_need(it.buffer_kind, it.request_size);
      for (i = 0; i < blk_cnt; i++) if (blk_fr[i] && blk_len[i] >= need) break;
      if (i >= blk_cnt) begin
        res.status = ST_NO_FIT;
      end else if (blk_len[i] != need && blk_cnt >= NBLK) begin
        res.status = ST_FULL;
      end else begin
        if (blk_len[i] != need) begin
          for (int j = blk_cnt; j > i; j--) begin
            blk_off[j] = blk_off[j-1]; blk_len[j] = blk_len[j-1]; blk_fr[j] = blk_fr[j-1];
          end
          blk_cnt++;
          blk_len[i] = need;
          blk_off[i+1] = blk_off[i] + need[31:0];
          blk_len[i+1] = blk_len[i+1] - need;
          blk_fr[i+1] = 1'b1;
        end
        blk_fr[i] = 1'b0;
        in_use = in_use + need[31:0];
        res.status = ST_OK;
        res.result_offset = blk_off[i];
        res.granted_size = need[31:0];
        live_off.insert(live_off.size(), blk_off[i]);
        live_len.insert(live_len.size(), need[31:0]);
      end
    end else begin
      for (i = 0; i < blk_cnt; i++)
        if (!blk_fr[i] && blk_off[i] == it.block_offset && blk_len[i] == {1'b0, it.request_size})
          break;
      if (i >= blk_cnt) begin
        res.status = ST_NO_MATCH;
      end else begin
        blk_fr[i] = 1'b1;
        in_use = (in_use >= it.request_size) ? in_use - it.request_size : '0;
        join_next(i);
        if (i > 0) join_next(i - 1);
        res.status = ST_OK;
        res.granted_size = it.request_size;
        foreach (live_off[k]) if (live_off[k] == it.block_offset) begin
          live_off.delete(k); live_len.delete(k); break;
        end
      end
    end
    res.used_bytes = in_use;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
    errors++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer", 32'd0, 32'd0);
      end else begin
        w = pending_q.pop_front();
        if (out_data.status !== w.status)
          report_mismatch("status", 32'(out_data.status), 32'(w.status));
        if (out_data.result_offset !== w.result_offset)
          report_mismatch("result_offset", out_data.result_offset, w.result_offset);
        if (out_data.granted_size !== w.granted_size)
          report_mismatch("granted_size", out_data.granted_size, w.granted_size);
        if (out_data.used_bytes !== w.used_bytes)
          report_mismatch("used_bytes", out_data.used_bytes, w.used_bytes);
      end
      n_results++;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog expired");
      $display("first_fit_block_allocator_core_tb: errors");
      $finish;
    end
  end

  task automatic send_command(input logic cmd, input logic [1:0] kind,
                              input logic [31:0] sz, input logic [31:0] off);
    in_item_t it;
    out_item_t res;
    it.command = cmd; it.buffer_kind = kind; it.request_size = sz; it.block_offset = off;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(it, res);
    pending_q.insert(pending_q.size(), res);
    n_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_pool(input logic [31:0] sz);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_reload(sz);
    @(posedge clk);
  endtask

  task automatic test_directed();
    write_pool(32'd1024);
    send_command(CMD_ALLOC, 2'd0, 32'd0, 32'd0);
    send_command(CMD_FREE, 2'd0, 32'd0, 32'd0);
    send_command(CMD_ALLOC, KIND_CONSTANT, 32'd1, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 2'd1, 32'd100, 32'd0);
    send_command(CMD_ALLOC, 2'd3, 32'd200, 32'd0);
    send_command(CMD_ALLOC, 2'd0, 32'd2000, 32'd0);
    send_command(CMD_FREE, 2'd0, 32'd100, 32'd17);
    send_command(CMD_FREE, 2'd1, 32'd100, 32'd16);
    send_command(CMD_FREE, 2'd3, 32'd200, 32'd116);
    send_command(CMD_ALLOC, 2'd0, 32'd1024, 32'd0);
    send_command(CMD_FREE, 2'd0, 32'd1024, 32'd0);
    send_command(CMD_ALLOC, KIND_CONSTANT, 32'hFFFF_FFFF, 32'd0);
    write_pool(32'hFFFF_FFFF);
    send_command(CMD_ALLOC, KIND_CONSTANT, 32'hFFFF_FFF1, 32'd0);
    send_command(CMD_ALLOC, 2'd0, 32'hFFFF_FFFF, 32'd0);
    send_command(CMD_FREE, 2'd2, 32'hFFFF_FFFF, 32'd0);
    write_pool(32'd0);
    send_command(CMD_ALLOC, 2'd0, 32'd1, 32'd0);
    write_pool(32'd40);
    for (int k = 0; k < 33; k++) send_command(CMD_ALLOC, 2'd0, 32'd1, 32'd0);
  endtask

  task automatic random_phase(input int count, input int sidle, input int rstall);
    int pick;
    logic [31:0] sz;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(pool_bytes / 20 + 1, 1);
        send_command(CMD_ALLOC, 2'($urandom_range(3)), sz, $urandom());
      end else if (pick < 85 && live_off.size() != 0) begin
        pick = $urandom_range(live_off.size() - 1);
        send_command(CMD_FREE, 2'($urandom_range(3)), live_len[pick], live_off[pick]);
      end else begin
        send_command(1'($urandom_range(1)), 2'($urandom_range(3)),
                     ($urandom_range(7) == 0) ? 32'd0 : $urandom(), $urandom());
      end
    end
  endtask

  task automatic test_random();
    write_pool(32'd4096);
    random_phase(190, 0, 0);
    write_pool($urandom_range(65535, 256));
    random_phase(180, 60, 0);
    write_pool(POOL_SIZE_RST);
    random_phase(180, 0, 60);
    write_pool($urandom());
    random_phase(180, 28, 28);
  endtask

  initial begin
    table_reload(POOL_SIZE_RST);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain_results();
    $display("covered %0d commands and %0d results over several pool sizes and four pacing modes",
             n_items, n_results);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("first_fit_block_allocator_core_tb: clean");
    end else begin
      $display("first_fit_block_allocator_core_tb: errors");
    end
    $finish;
  end
endmodule
